[rtl/rwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwm_pkg
// Shared types and constants of the random waypoint mobility step block.
// ----------------------------------------------------------------------------
package rwm_pkg;

   localparam int NODE_COUNT = 64;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int REQ_W      = 80;
   localparam int RSP_W      = 104;
   localparam int CSR_AW     = 3;
   localparam logic [23:0] POS_MAX = 24'hFFFFFF;

   typedef enum logic [2:0] {
      CMD_INIT   = 3'd0,
      CMD_CENTRE = 3'd1,
      CMD_TICK   = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_RESUME = 3'd4,
      CMD_FINISH = 3'd5
   } cmd_type;

   localparam logic [CSR_AW-1:0] CSR_MAP_X     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MAP_Y     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MAP_Z     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MIN_SPEED = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MAX_SPEED = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_TIME_STEP = 3'd5;

   typedef struct packed {
      logic [2:0][23:0] cur;
      logic [2:0][23:0] src;
      logic [2:0][23:0] dst;
      logic [2:0][24:0] vel;
      logic [15:0]      speed;
      logic             pending;
      logic             fin;
   } node_type;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_LOAD  = 11'b00000000010,
      S_EXEC  = 11'b00000000100,
      S_SQSUM = 11'b00000001000,
      S_SQRT  = 11'b00000010000,
      S_DINIT = 11'b00000100000,
      S_DIV   = 11'b00001000000,
      S_LEG   = 11'b00010000000,
      S_STEP  = 11'b00100000000,
      S_MOVE  = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

endpackage

[rtl/rwm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/random_waypoint_mobility_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_waypoint_mobility_step
// Per-node random waypoint motion engine; node state in one RAM, one request
// handled at a time by a read-modify-write sequencer.
// A tick that starts a new leg runs a 25-step square root and three parallel
// 24-step dividers. A new request is accepted only in the idle state, once
// the last one is done; a pending result does not block accept.
// Reset: synchronous; the state, the response valid flag and the CSRs go to
// defaults, and all node entries are marked unwritten.
// ----------------------------------------------------------------------------
module random_waypoint_mobility_step (
   input  logic                      clock,
   input  logic                      reset,
   // command, node_id, powered, rand_x, rand_y, rand_z, rand_speed
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [rwm_pkg::REQ_W-1:0] req_tdata,
   // node_out, pos_x, pos_y, pos_z, leg_speed, arrived, new_leg, resample
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [rwm_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rwm_pkg::CSR_AW-1:0] csr_index,
   input  logic [15:0]               csr_data
);
   import rwm_pkg::*;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [5:0]       id_ff, id_in;
   logic             pw_ff, pw_in;
   logic [2:0][15:0] rnd_ff, rnd_in;
   logic [15:0]      rsp_rnd_ff, rsp_rnd_in;
   node_type         node_ff, node_in;
   logic [2:0][23:0] tgt_ff, tgt_in;
   logic [15:0]      spd_ff, spd_in;
   logic [2:0][23:0] mag_ff, mag_in;
   logic [2:0][47:0] sq_ff, sq_in;
   logic [49:0]      rad_ff, rad_in;
   logic [27:0]      rem_ff, rem_in;
   logic [24:0]      root_ff, root_in;
   logic [2:0][47:0] prod_ff, prod_in;
   logic [2:0][25:0] drem_ff, drem_in;
   logic [2:0][23:0] quo_ff, quo_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [2:0][23:0] st_ff, st_in;
   logic [1:0]       axis_ff, axis_in;
   logic             arr_ff, arr_in, new_ff, new_in, res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [NODE_COUNT-1:0] valid_ff, valid_in;

   logic [2:0][15:0] wid_ff;
   logic [15:0]      min_ff, max_ff, ts_ff;

   logic             ram_wr, ram_rd;
   logic [NODE_AW-1:0] ram_rd_addr;
   node_type         ram_rd_data;
   logic             in_range;

   rwm_ram #(
      .WIDTH($bits(node_type)),
      .DEPTH(NODE_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(NODE_AW'(id_ff)),
      .wr_data(node_ff),
      .rd_en  (ram_rd),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign in_range   = 32'(id_ff) < NODE_COUNT;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff <= {16'd0, 16'd1000, 16'd1000};
         min_ff <= 16'd256;
         max_ff <= 16'd2560;
         ts_ff  <= 16'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAP_X:     wid_ff[0] <= csr_data;
            CSR_MAP_Y:     wid_ff[1] <= csr_data;
            CSR_MAP_Z:     wid_ff[2] <= csr_data;
            CSR_MIN_SPEED: min_ff    <= csr_data;
            CSR_MAX_SPEED: max_ff    <= csr_data;
            CSR_TIME_STEP: ts_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [31:0] rprod;
      logic [15:0] diff;
      logic [27:0] rem_sh, trial;
      logic [25:0] dsh;
      logic [39:0] sprod;
      logic [23:0] av, m0, m1, m2;
      logic [25:0] np;
      logic [23:0] npc [3];
      logic [49:0] sum;
      logic        hit;
      logic [24:0] vp;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      pw_in        = pw_ff;
      rnd_in       = rnd_ff;
      rsp_rnd_in   = rsp_rnd_ff;
      node_in      = node_ff;
      tgt_in       = tgt_ff;
      spd_in       = spd_ff;
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      prod_in      = prod_ff;
      drem_in      = drem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      axis_in      = axis_ff;
      arr_in       = arr_ff;
      new_in       = new_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ram_wr       = 1'b0;
      ram_rd       = 1'b0;
      ram_rd_addr  = NODE_AW'(req_tdata[8:3]);
      rprod = '0; diff = '0; rem_sh = '0; trial = '0; dsh = '0; sprod = '0;
      av = '0; m0 = '0; m1 = '0; m2 = '0; np = '0; sum = '0; hit = 1'b0; vp = '0;
      for (int a = 0; a < 3; a++) begin
         npc[a] = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = cmd_type'(req_tdata[2:0]);
               id_in      = req_tdata[8:3];
               pw_in      = req_tdata[9];
               rnd_in[0]  = req_tdata[25:10];
               rnd_in[1]  = req_tdata[41:26];
               rnd_in[2]  = req_tdata[57:42];
               rsp_rnd_in = req_tdata[73:58];
               ram_rd     = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            node_in = ram_rd_data;
            if (!valid_ff[NODE_AW'(id_ff)]) begin
               node_in.vel     = '0;
               node_in.speed   = '0;
               node_in.pending = 1'b1;
               node_in.fin     = 1'b0;
            end
            for (int a = 0; a < 3; a++) begin
               rprod     = 32'(rnd_ff[a]) * 32'(wid_ff[a]);
               tgt_in[a] = rprod[31:8];
            end
            if (max_ff >= min_ff) begin
               diff   = max_ff - min_ff;
               rprod  = 32'(rsp_rnd_ff) * 32'(diff);
               spd_in = min_ff + rprod[31:16];
            end else begin
               diff   = min_ff - max_ff;
               rprod  = 32'(rsp_rnd_ff) * 32'(diff);
               spd_in = min_ff - rprod[31:16];
            end
            arr_in   = 1'b0;
            new_in   = 1'b0;
            res_in   = 1'b0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (in_range) begin
               case (cmd_ff)
                  CMD_INIT: begin
                     node_in.cur     = tgt_ff;
                     node_in.src     = tgt_ff;
                     node_in.dst     = tgt_ff;
                     node_in.vel     = '0;
                     node_in.speed   = '0;
                     node_in.pending = 1'b1;
                     node_in.fin     = 1'b0;
                  end
                  CMD_CENTRE: begin
                     for (int a = 0; a < 3; a++) begin
                        node_in.cur[a] = {1'b0, wid_ff[a], 7'd0};
                        node_in.src[a] = {1'b0, wid_ff[a], 7'd0};
                        node_in.dst[a] = {1'b0, wid_ff[a], 7'd0};
                     end
                  end
                  CMD_TICK: begin
                     if (pw_ff && !node_ff.fin) begin
                        if (node_ff.pending) begin
                           if (tgt_ff == node_ff.src) begin
                              res_in = 1'b1;
                           end else begin
                              node_in.dst = tgt_ff;
                              for (int a = 0; a < 3; a++) begin
                                 m0 = (tgt_ff[a] >= node_ff.src[a]) ?
                                      tgt_ff[a] - node_ff.src[a] :
                                      node_ff.src[a] - tgt_ff[a];
                                 mag_in[a] = m0;
                                 sq_in[a]  = 48'(m0) * 48'(m0);
                              end
                              state_in = S_SQSUM;
                           end
                        end else if (ts_ff != '0) begin
                           state_in = S_STEP;
                        end
                     end
                  end
                  CMD_STOP: begin
                     node_in.vel   = '0;
                     node_in.speed = '0;
                  end
                  CMD_RESUME: begin
                     node_in.src     = node_ff.cur;
                     node_in.dst     = node_ff.cur;
                     node_in.pending = 1'b1;
                  end
                  CMD_FINISH: node_in.fin = 1'b1;
                  default: ;
               endcase
            end
         end
         S_SQSUM: begin
            sum = 50'(sq_ff[0]) + 50'(sq_ff[1]) + 50'(sq_ff[2]);
            rad_in  = sum;
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
            for (int a = 0; a < 3; a++) begin
               sprod      = 40'(mag_ff[a]) * 40'(spd_ff);
               prod_in[a] = {sprod, 8'd0};
            end
            state_in = S_SQRT;
         end
         S_SQRT: begin
            rem_sh = {rem_ff[25:0], rad_ff[49:48]};
            trial  = {1'b0, root_ff, 2'b01};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[23:0], 1'b0};
            end
            rad_in = {rad_ff[47:0], 2'b00};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd24) begin
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            if (root_ff == '0) begin
               root_in = 25'd1;
            end
            for (int a = 0; a < 3; a++) begin
               drem_in[a] = {2'b00, prod_ff[a][47:24]};
               prod_in[a] = {prod_ff[a][23:0], 24'd0};
            end
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            for (int a = 0; a < 3; a++) begin
               dsh = {drem_ff[a][24:0], prod_ff[a][47]};
               if (dsh >= {1'b0, root_ff}) begin
                  drem_in[a] = dsh - {1'b0, root_ff};
                  quo_in[a]  = {quo_ff[a][22:0], 1'b1};
               end else begin
                  drem_in[a] = dsh;
                  quo_in[a]  = {quo_ff[a][22:0], 1'b0};
               end
               prod_in[a] = {prod_ff[a][46:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) begin
               state_in = S_LEG;
            end
         end
         S_LEG: begin
            for (int a = 0; a < 3; a++) begin
               node_in.vel[a] = (node_ff.dst[a] >= node_ff.src[a]) ?
                                {1'b0, quo_ff[a]} : -{1'b0, quo_ff[a]};
            end
            node_in.speed   = spd_ff;
            node_in.pending = 1'b0;
            new_in          = 1'b1;
            state_in        = (ts_ff != '0) ? S_STEP : S_DONE;
         end
         S_STEP: begin
            for (int a = 0; a < 3; a++) begin
               vp    = node_ff.vel[a][24] ? -node_ff.vel[a] : node_ff.vel[a];
               av    = vp[23:0];
               sprod = 40'(av) * 40'(ts_ff);
               st_in[a] = sprod[39:16];
            end
            m0 = (node_ff.dst[0] >= node_ff.src[0]) ? node_ff.dst[0] - node_ff.src[0] :
                 node_ff.src[0] - node_ff.dst[0];
            m1 = (node_ff.dst[1] >= node_ff.src[1]) ? node_ff.dst[1] - node_ff.src[1] :
                 node_ff.src[1] - node_ff.dst[1];
            m2 = (node_ff.dst[2] >= node_ff.src[2]) ? node_ff.dst[2] - node_ff.src[2] :
                 node_ff.src[2] - node_ff.dst[2];
            axis_in = 2'd0;
            av      = m0;
            if (m1 > av) begin
               axis_in = 2'd1;
               av      = m1;
            end
            if (m2 > av) begin
               axis_in = 2'd2;
            end
            state_in = S_MOVE;
         end
         S_MOVE: begin
            for (int a = 0; a < 3; a++) begin
               if (node_ff.vel[a][24]) begin
                  np = {2'b00, node_ff.cur[a]} - {2'b00, st_ff[a]};
               end else begin
                  np = {2'b00, node_ff.cur[a]} + {2'b00, st_ff[a]};
               end
               if (np[25]) begin
                  npc[a] = '0;
               end else if (np[24]) begin
                  npc[a] = POS_MAX;
               end else begin
                  npc[a] = np[23:0];
               end
            end
            vp  = node_ff.vel[axis_ff];
            hit = (!vp[24] && vp != '0 && npc[axis_ff] >= node_ff.dst[axis_ff]) ||
                  (vp[24] && npc[axis_ff] <= node_ff.dst[axis_ff]);
            if (hit) begin
               node_in.cur     = node_ff.dst;
               node_in.src     = node_ff.dst;
               node_in.pending = 1'b1;
               arr_in          = 1'b1;
            end else begin
               for (int a = 0; a < 3; a++) begin
                  node_in.cur[a] = npc[a];
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (in_range) begin
                  rsp_data_in = {7'd0, res_ff, new_ff, arr_ff, node_ff.speed,
                                 node_ff.cur[2], node_ff.cur[1], node_ff.cur[0], id_ff};
                  ram_wr = 1'b1;
                  valid_in[NODE_AW'(id_ff)] = 1'b1;
               end else begin
                  rsp_data_in = {98'd0, id_ff};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      pw_ff       <= pw_in;
      rnd_ff      <= rnd_in;
      rsp_rnd_ff  <= rsp_rnd_in;
      node_ff     <= node_in;
      tgt_ff      <= tgt_in;
      spd_ff      <= spd_in;
      mag_ff      <= mag_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      prod_ff     <= prod_in;
      drem_ff     <= drem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      st_ff       <= st_in;
      axis_ff     <= axis_in;
      arr_ff      <= arr_in;
      new_ff      <= new_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the random waypoint mobility step block. Node
// commands go in from a queue with bursty valid; every accepted request is
// run through a local mobility predictor and the expected node report is
// compared field by field with what comes back under random backpressure.
// Several map, speed and time-step settings are swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import rwm_pkg::*;

   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [2:0]  command;
      logic [5:0]  node;
      logic        powered;
      logic [15:0] rx, ry, rz, rs;
   } mob_cmd_type;

   typedef struct {
      logic [5:0]  node;
      logic [23:0] px, py, pz;
      logic [15:0] speed;
      logic        arrived, new_leg, resample;
   } node_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   random_waypoint_mobility_step dut (.*);

   always #2 clock = ~clock;

   // register mirror
   logic [15:0] width_m [3];
   logic [15:0] min_spd_m, max_spd_m, tstep_m;

   // node table mirror
   logic [23:0] cur_m [NODE_COUNT][3];
   logic [23:0] src_m [NODE_COUNT][3];
   logic [23:0] dst_m [NODE_COUNT][3];
   int          vel_m [NODE_COUNT][3];
   logic [15:0] spd_m [NODE_COUNT];
   bit          pend_m [NODE_COUNT];
   bit          fin_m [NODE_COUNT];
   bit          placed [NODE_COUNT];

   mob_cmd_type     pending_cmds [$];
   node_report_type expected_reports [$];
   int errors = 0;
   int cycles = 0;

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [23:0] rand_coord(logic [15:0] r, logic [15:0] w);
      longint unsigned p;
      p = (longint'(r) * longint'(w)) >> 8;
      return p[23:0];
   endfunction

   function automatic void predict_report(mob_cmd_type c);
      node_report_type e;
      logic [15:0] rnd [3];
      logic [23:0] t [3];
      longint unsigned mag [3];
      longint unsigned sum, leg_len, m, av, st, spd;
      longint np [3];
      int n, p, v;
      logic [23:0] best, d;
      bit same;
      n = c.node;
      rnd[0] = c.rx; rnd[1] = c.ry; rnd[2] = c.rz;
      e.node = c.node;
      e.arrived = 0; e.new_leg = 0; e.resample = 0;
      case (c.command)
         CMD_INIT: begin
            for (int a = 0; a < 3; a++) begin
               cur_m[n][a] = rand_coord(rnd[a], width_m[a]);
               src_m[n][a] = cur_m[n][a];
               dst_m[n][a] = cur_m[n][a];
               vel_m[n][a] = 0;
            end
            spd_m[n] = 0; pend_m[n] = 1; fin_m[n] = 0;
         end
         CMD_CENTRE: begin
            for (int a = 0; a < 3; a++) begin
               cur_m[n][a] = {1'b0, width_m[a], 7'd0};
               src_m[n][a] = cur_m[n][a];
               dst_m[n][a] = cur_m[n][a];
            end
         end
         CMD_TICK: if (c.powered && !fin_m[n]) begin
            same = 1;
            if (pend_m[n]) begin
               for (int a = 0; a < 3; a++) begin
                  t[a] = rand_coord(rnd[a], width_m[a]);
                  if (t[a] != src_m[n][a]) same = 0;
               end
               if (same) begin
                  e.resample = 1;
               end else begin
                  if (max_spd_m >= min_spd_m)
                     spd = min_spd_m + ((longint'(c.rs) * (max_spd_m - min_spd_m)) >> 16);
                  else
                     spd = min_spd_m - ((longint'(c.rs) * (min_spd_m - max_spd_m)) >> 16);
                  spd = spd & 64'hFFFF;
                  sum = 0;
                  for (int a = 0; a < 3; a++) begin
                     dst_m[n][a] = t[a];
                     mag[a] = (t[a] >= src_m[n][a]) ? t[a] - src_m[n][a] : src_m[n][a] - t[a];
                     sum += mag[a] * mag[a];
                  end
                  leg_len = isqrt(sum);
                  if (leg_len == 0) leg_len = 1;
                  for (int a = 0; a < 3; a++) begin
                     m = (mag[a] * spd * 256) / leg_len;
                     v = int'(m & 64'h7FFFFFFF);
                     vel_m[n][a] = (t[a] >= src_m[n][a]) ? v : -v;
                  end
                  spd_m[n] = spd[15:0];
                  pend_m[n] = 0;
                  e.new_leg = 1;
               end
            end
            if (!e.resample && tstep_m != 0) begin
               p = 0; best = 0;
               for (int a = 0; a < 3; a++) begin
                  d = (dst_m[n][a] >= src_m[n][a]) ? dst_m[n][a] - src_m[n][a]
                                                   : src_m[n][a] - dst_m[n][a];
                  if (a == 0 || d > best) begin
                     best = d; p = a;
                  end
               end
               for (int a = 0; a < 3; a++) begin
                  av = (vel_m[n][a] < 0) ? -longint'(vel_m[n][a]) : longint'(vel_m[n][a]);
                  st = (av * tstep_m) >> 16;
                  np[a] = longint'(cur_m[n][a]) + ((vel_m[n][a] < 0) ? -longint'(st)
                                                                      : longint'(st));
                  if (np[a] < 0) np[a] = 0;
                  if (np[a] > longint'(POS_MAX)) np[a] = longint'(POS_MAX);
               end
               if ((vel_m[n][p] > 0 && np[p] >= longint'(dst_m[n][p])) ||
                   (vel_m[n][p] < 0 && np[p] <= longint'(dst_m[n][p]))) begin
                  for (int a = 0; a < 3; a++) begin
                     cur_m[n][a] = dst_m[n][a];
                     src_m[n][a] = dst_m[n][a];
                  end
                  pend_m[n] = 1;
                  e.arrived = 1;
               end else begin
                  for (int a = 0; a < 3; a++) cur_m[n][a] = np[a][23:0];
               end
            end
         end
         CMD_STOP: begin
            for (int a = 0; a < 3; a++) vel_m[n][a] = 0;
            spd_m[n] = 0;
         end
         CMD_RESUME: begin
            for (int a = 0; a < 3; a++) begin
               src_m[n][a] = cur_m[n][a];
               dst_m[n][a] = cur_m[n][a];
            end
            pend_m[n] = 1;
         end
         CMD_FINISH: fin_m[n] = 1;
         default: ;
      endcase
      e.px = cur_m[n][0]; e.py = cur_m[n][1]; e.pz = cur_m[n][2];
      e.speed = spd_m[n];
      expected_reports.push_back(e);
   endfunction

   // request driver: bursts with random gaps
   mob_cmd_type drv_cmd;
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) predict_report(drv_cmd);
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            drv_cmd = pending_cmds.pop_front();
            req_tdata <= {6'd0, drv_cmd.rs, drv_cmd.rz, drv_cmd.ry, drv_cmd.rx,
                          drv_cmd.powered, drv_cmd.node, drv_cmd.command};
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response sink: random stall pattern, redrawn periodically
   int stall_mode = 0;
   int mode_cnt = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_cnt = 50;
         end
         mode_cnt--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= mode_cnt[2];
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      node_report_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_reports.pop_front();
            if (rsp_tdata[5:0] !== e.node) begin
               $error("node_out exp %0d got %0d", e.node, rsp_tdata[5:0]); errors++;
            end
            if (rsp_tdata[29:6] !== e.px) begin
               $error("pos_x exp %h got %h", e.px, rsp_tdata[29:6]); errors++;
            end
            if (rsp_tdata[53:30] !== e.py) begin
               $error("pos_y exp %h got %h", e.py, rsp_tdata[53:30]); errors++;
            end
            if (rsp_tdata[77:54] !== e.pz) begin
               $error("pos_z exp %h got %h", e.pz, rsp_tdata[77:54]); errors++;
            end
            if (rsp_tdata[93:78] !== e.speed) begin
               $error("leg_speed exp %h got %h", e.speed, rsp_tdata[93:78]); errors++;
            end
            if (rsp_tdata[94] !== e.arrived) begin
               $error("arrived exp %b got %b", e.arrived, rsp_tdata[94]); errors++;
            end
            if (rsp_tdata[95] !== e.new_leg) begin
               $error("new_leg exp %b got %b", e.new_leg, rsp_tdata[95]); errors++;
            end
            if (rsp_tdata[96] !== e.resample) begin
               $error("resample exp %b got %b", e.resample, rsp_tdata[96]); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("random_waypoint_mobility_step regression: fail");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_AW-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAP_X: width_m[0] = val;
         CSR_MAP_Y: width_m[1] = val;
         CSR_MAP_Z: width_m[2] = val;
         CSR_MIN_SPEED: min_spd_m = val;
         CSR_MAX_SPEED: max_spd_m = val;
         CSR_TIME_STEP: tstep_m = val;
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [15:0] wx, wy, wz, smin, smax, ts);
      write_csr(CSR_MAP_X, wx);
      write_csr(CSR_MAP_Y, wy);
      write_csr(CSR_MAP_Z, wz);
      write_csr(CSR_MIN_SPEED, smin);
      write_csr(CSR_MAX_SPEED, smax);
      write_csr(CSR_TIME_STEP, ts);
   endtask

   task automatic push_cmd(logic [2:0] cmd, logic [5:0] node, logic pw,
                           logic [15:0] rx, ry, rz, rs);
      mob_cmd_type c;
      c.command = cmd; c.node = node; c.powered = pw;
      c.rx = rx; c.ry = ry; c.rz = rz; c.rs = rs;
      if (cmd == CMD_INIT || cmd == CMD_CENTRE) placed[node] = 1;
      pending_cmds.push_back(c);
   endtask

   task automatic push_random(int count);
      logic [2:0] cmd;
      logic [5:0] node;
      int w;
      repeat (count) begin
         node = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 7))
                                            : 6'($urandom_range(0, 63));
         w = $urandom_range(0, 99);
         if (w < 62) cmd = CMD_TICK;
         else if (w < 71) cmd = CMD_INIT;
         else if (w < 75) cmd = CMD_CENTRE;
         else if (w < 82) cmd = CMD_STOP;
         else if (w < 91) cmd = CMD_RESUME;
         else if (w < 95) cmd = CMD_FINISH;
         else cmd = w[0] ? CMD_SPARE_LO : CMD_SPARE_HI;
         // never send other commands to an entry that was never placed
         if (!placed[node]) cmd = CMD_INIT;
         push_cmd(cmd, node, $urandom_range(0, 9) != 0, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() > 0 || req_tvalid || expected_reports.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      width_m[0] = 1000; width_m[1] = 1000; width_m[2] = 0;
      min_spd_m = 256; max_spd_m = 2560; tstep_m = 256;
      for (int n = 0; n < NODE_COUNT; n++) begin
         for (int a = 0; a < 3; a++) vel_m[n][a] = 0;
         spd_m[n] = 0; pend_m[n] = 1; fin_m[n] = 0; placed[n] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults first
      push_cmd(CMD_INIT, 6'd0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      push_cmd(CMD_CENTRE, 6'd1, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_TICK, 6'd0, 0, 16'h1234, 16'h8000, 16'h0000, 16'hFFFF);
      push_cmd(CMD_TICK, 6'd0, 1, 16'h1234, 16'h8000, 16'h0000, 16'hFFFF);
      push_cmd(CMD_TICK, 6'd0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_STOP, 6'd0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_TICK, 6'd0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_RESUME, 6'd0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_TICK, 6'd0, 1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      push_cmd(CMD_FINISH, 6'd0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_TICK, 6'd0, 1, 16'h4444, 16'h4444, 16'h4444, 16'h4444);
      push_cmd(CMD_SPARE_LO, 6'd0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_SPARE_HI, 6'd1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_cmd(CMD_INIT, 6'd0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_INIT, 6'd63, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      // target equal to start
      push_cmd(CMD_TICK, 6'd63, 1, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
      push_cmd(CMD_TICK, 6'd1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_random(250);
      wait_idle();

      // small map, quick arrivals
      set_regs(16'd20, 16'd20, 16'd0, 16'd256, 16'd2560, 16'd256);
      push_cmd(CMD_INIT, 6'd2, 1, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      push_cmd(CMD_TICK, 6'd2, 1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      push_cmd(CMD_TICK, 6'd2, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_TICK, 6'd2, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_random(260);
      wait_idle();

      // extremes, max below min
      set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
      push_cmd(CMD_INIT, 6'd3, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_cmd(CMD_TICK, 6'd3, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      push_cmd(CMD_CENTRE, 6'd4, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_random(260);
      wait_idle();

      // zero map, zero speed, zero time step
      set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      push_random(200);
      wait_idle();

      // tiny map, full speed range
      set_regs(16'd5, 16'd3, 16'd7, 16'd0, 16'hFFFF, 16'd128);
      push_random(300);
      wait_idle();

      set_regs(16'd300, 16'd200, 16'd100, 16'd512, 16'd8192, 16'd1024);
      push_random(280);
      wait_idle();

      if (errors == 0) begin
         $display("random_waypoint_mobility_step regression: pass");
      end else begin
         $display("random_waypoint_mobility_step regression: fail");
      end
      $finish;
   end

endmodule
